>>> hdl/cwb_pkg.sv
// ============================================================================
// cwb_pkg
// Shared types and constants for the white-balance color classifier.
// ============================================================================
package cwb_pkg;

    localparam int LEVEL_W   = 8;
    localparam int DIV_STEPS = 8;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int OUT_W     = 32;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL      = 8'd255;
    localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 8'd100;

    localparam logic [0:0] REG_THRESHOLD = 1'b0;

    localparam logic ACT_CALIBRATE = 1'b0;
    localparam logic ACT_MEASURE   = 1'b1;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic [1:0] CLASS_RED   = 2'd0;
    localparam logic [1:0] CLASS_GREEN = 2'd1;
    localparam logic [1:0] CLASS_BLUE  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_DIV,
        ST_SAVE,
        ST_EMIT
    } cwb_state_t;

    typedef struct packed {
        logic       load_counts;
        logic       load_factors;
        logic       div_init;
        logic       div_step;
        logic       save;
        logic       emit;
        logic [1:0] chan;
    } cwb_cmd_t;

    typedef struct packed {
        logic out_busy;
    } cwb_stat_t;

endpackage

>>> hdl/cwb_ctrl.sv
// ============================================================================
// cwb_ctrl
// Sequencer: accepts beats, walks the three channels through the shared
// divider and hands the result to the output register.
// ============================================================================
module cwb_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             action,
    output logic             s_tready,
    input  cwb_pkg::cwb_stat_t stat,
    output cwb_pkg::cwb_cmd_t  cmd
);
    import cwb_pkg::*;

    localparam logic [2:0] LAST_STEP = 3'(DIV_STEPS - 1);

    cwb_state_t state_reg;
    cwb_state_t state_next;
    logic [1:0] ch_reg;
    logic [1:0] ch_next;
    logic [2:0] step_reg;
    logic [2:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= CH_RED;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.chan   = ch_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (action == ACT_MEASURE)
                    begin
                        cmd.load_counts = 1'b1;
                        ch_next         = CH_RED;
                        state_next      = ST_INIT;
                    end
                    else
                    begin
                        cmd.load_factors = 1'b1;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_SAVE;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_SAVE:
            begin
                cmd.save = 1'b1;
                if (ch_reg == CH_BLUE)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = ST_INIT;
                end
            end
            ST_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/cwb_datapath.sv
// ============================================================================
// cwb_datapath
// White factors, count registers, shared restoring divider, level registers,
// classification and the output register.
// ============================================================================
module cwb_datapath #(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cwb_pkg::cwb_cmd_t      cmd,
    input  logic [COUNT_WIDTH-1:0] red_count,
    input  logic [COUNT_WIDTH-1:0] green_count,
    input  logic [COUNT_WIDTH-1:0] blue_count,
    input  logic [7:0]             threshold,
    input  logic                   m_tready,
    output cwb_pkg::cwb_stat_t     stat,
    output logic                   m_tvalid,
    output logic [31:0]            m_tdata
);
    import cwb_pkg::*;

    localparam int CW = COUNT_WIDTH;
    localparam int PW = COUNT_WIDTH + LEVEL_W;

    logic [CW-1:0] red_factor_reg, green_factor_reg, blue_factor_reg;
    logic [CW-1:0] red_count_reg, green_count_reg, blue_count_reg;
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] rem_next;
    logic [LEVEL_W-1:0] lo_reg, lo_next;
    logic [LEVEL_W-1:0] quo_reg, quo_next;
    logic sat_reg, sat_next;
    logic [LEVEL_W-1:0] red_level_reg, green_level_reg, blue_level_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic out_valid_reg, out_valid_next;

    logic [CW-1:0] count_sel, factor_sel;
    logic [PW-1:0] product;
    logic [CW:0]   trial;
    logic          fits;
    logic [LEVEL_W-1:0] level;
    logic [1:0]    color_class;

    always_comb
    begin
        case (cmd.chan)
            CH_RED:
            begin
                count_sel  = red_count_reg;
                factor_sel = red_factor_reg;
            end
            CH_GREEN:
            begin
                count_sel  = green_count_reg;
                factor_sel = green_factor_reg;
            end
            default:
            begin
                count_sel  = blue_count_reg;
                factor_sel = blue_factor_reg;
            end
        endcase
    end

    // count * 255 as (count << 8) - count
    assign product = {count_sel, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, count_sel};
    assign trial   = {rem_reg, lo_reg[LEVEL_W-1]};
    assign fits    = trial >= {1'b0, factor_sel};
    assign level   = sat_reg ? FULL_LEVEL : quo_reg;

    always_comb
    begin
        rem_next = rem_reg;
        lo_next  = lo_reg;
        quo_next = quo_reg;
        sat_next = sat_reg;
        if (cmd.div_init)
        begin
            rem_next = product[PW-1:LEVEL_W];
            lo_next  = product[LEVEL_W-1:0];
            quo_next = '0;
            sat_next = product[PW-1:LEVEL_W] >= factor_sel;
        end
        else if (cmd.div_step)
        begin
            lo_next  = {lo_reg[LEVEL_W-2:0], 1'b0};
            quo_next = {quo_reg[LEVEL_W-2:0], fits};
            rem_next = fits ? CW'(trial - {1'b0, factor_sel}) : trial[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        quo_reg <= quo_next;
        sat_reg <= sat_next;
        if (cmd.load_counts)
        begin
            red_count_reg   <= red_count;
            green_count_reg <= green_count;
            blue_count_reg  <= blue_count;
        end
        if (cmd.save)
        begin
            case (cmd.chan)
                CH_RED:   red_level_reg   <= level;
                CH_GREEN: green_level_reg <= level;
                default:  blue_level_reg  <= level;
            endcase
        end
        if (cmd.emit)
        begin
            out_data_reg <= {6'b0, color_class, blue_level_reg, green_level_reg,
                             red_level_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_factor_reg   <= CW'(FULL_LEVEL);
            green_factor_reg <= CW'(FULL_LEVEL);
            blue_factor_reg  <= CW'(FULL_LEVEL);
        end
        else if (cmd.load_factors)
        begin
            red_factor_reg   <= red_count;
            green_factor_reg <= green_count;
            blue_factor_reg  <= blue_count;
        end
    end

    always_comb
    begin
        if (blue_level_reg > red_level_reg && blue_level_reg > green_level_reg
            && blue_level_reg > threshold)
        begin
            color_class = CLASS_BLUE;
        end
        else if (green_level_reg > red_level_reg && green_level_reg > blue_level_reg
                 && green_level_reg > threshold)
        begin
            color_class = CLASS_GREEN;
        end
        else
        begin
            color_class = CLASS_RED;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign stat.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;

endmodule

>>> hdl/color_white_balance_classifier.sv
// ============================================================================
// color_white_balance_classifier
// White-balanced RGB levels and dominant-color class from pulse counts.
// ============================================================================
// A calibrate beat (tuser 0) stores the three counts as white factors and
// returns nothing. A measure beat (tuser 1) returns one beat with each
// level = min(255, count*255/factor) (255 for a zero factor) and the color
// class. The result enters the output register from the EMIT state, once the
// sequencer has passed through INIT, DIV and SAVE for each channel, and the
// next beat can be accepted in the cycle after the hand-over. One shared
// restoring divider sets this pace: it yields one quotient bit per cycle,
// eight bits between a load (INIT) and a store (SAVE) for each of the three
// channels, then a hand-over (EMIT). The output register lets the next beat
// in while a result waits; a second result holds in the sequencer, with the
// input stalled, until the waiting beat is taken.
module color_white_balance_classifier #(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // red_count, green_count, blue_count, zero fill
    input  logic [((3*COUNT_WIDTH+7)/8)*8-1:0] s_tdata,
    // action
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // red_level, green_level, blue_level, color_class, zero fill
    output logic [31:0]                   m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cwb_pkg::ADDR_W-1:0]    paddr,
    input  logic [cwb_pkg::DATA_W-1:0]    pwdata,
    output logic [cwb_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import cwb_pkg::*;

    localparam int CW = COUNT_WIDTH;

    logic [LEVEL_W-1:0] threshold_reg;
    logic               reg_write;
    cwb_cmd_t           cmd;
    cwb_stat_t          stat;

    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && (paddr[2] == REG_THRESHOLD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (reg_write)
        begin
            threshold_reg <= pwdata[LEVEL_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_THRESHOLD) ?
                    {{(DATA_W-LEVEL_W){1'b0}}, threshold_reg} : '0;

    cwb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .action   (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cwb_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .red_count   (s_tdata[CW-1:0]),
        .green_count (s_tdata[2*CW-1:CW]),
        .blue_count  (s_tdata[3*CW-1:2*CW]),
        .threshold   (threshold_reg),
        .m_tready    (m_tready),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

`ifndef SYNTHESIS
    a_busy_after_measure: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == ACT_MEASURE |=> !s_tready)
        else $error("measure beat did not occupy the block");

    a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[25:24] != 2'd3)
        else $error("invalid color class");

    a_blue_dominant: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[25:24] == CLASS_BLUE |->
        m_tdata[23:16] > m_tdata[7:0] && m_tdata[23:16] > m_tdata[15:8])
        else $error("blue class without blue dominance");

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(m_tvalid && !m_tready))
        else $error("result overwrote a waiting beat");
`endif

endmodule
